// ----- src/lrupr_pkg.sv -----
// shared constants and types for the lru page replacement block
package lrupr_pkg;

    // fixed field widths of the ports
    localparam int PAGE_PORT_W = 16;
    localparam int SLOT_PORT_W = 4;
    localparam int CFG_W       = 5;
    localparam int FAULT_W     = 16;

    // defaults for the top level parameters
    localparam int DEF_MAX_FRAMES = 16;
    localparam int DEF_PAGE_BITS  = 16;

    // frame count after reset and saturation point of the fault count
    localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = CFG_W'(4);
    localparam logic [FAULT_W-1:0] FAULT_MAX       = {FAULT_W{1'b1}};

    // control broadcast from the top level to every frame cell
    typedef struct packed {
        logic step;   // an item is accepted this cycle
        logic clear;  // drop all frames (register write or last reference)
        logic miss;   // the page is resident in no active frame
        logic full;   // no active frame is empty
    } t_cell_ctrl;

endpackage

// ----- src/lru_page_replacement.sv -----
// Least recently used page replacement unit. One page reference is taken per
// beat and one result beat comes back for it. A reference is looked up, a
// frame is chosen and the table is updated in the cycle the beat is accepted;
// the result sits in an output register from the next cycle, and a new beat is
// taken in every cycle in which that register is empty or being drained, so the
// block sustains one reference per cycle. The cycle time is set by the ripple
// through the row of frame cells (page compare, first empty frame, oldest
// frame). Writing frame_count, or a reference marked last, clears the table
// and the fault count; frame_count of 0 acts as 1 and values above MAX_FRAMES
// act as MAX_FRAMES. A config write holds off the input for that cycle.
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_frame_count,
    // references
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [PAGE_PORT_W-1:0] i_page_number,
    input  logic                   i_last_reference,
    // results
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_hit,
    output logic [SLOT_PORT_W-1:0] o_frame_slot,
    output logic                   o_evicted_valid,
    output logic [PAGE_PORT_W-1:0] o_evicted_page,
    output logic [FAULT_W-1:0]     o_fault_total
);

    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int ACT_W  = $clog2(MAX_FRAMES + 1);
    localparam int CNT_W  = (ACT_W > CFG_W) ? ACT_W : CFG_W;

    logic                 w_in_fire;
    logic                 w_cfg_fire;
    logic [CFG_W-1:0]     r_frame_count;
    logic [CNT_W-1:0]     w_fc_ext;
    logic [CNT_W-1:0]     w_active;
    logic [SLOT_W-1:0]    w_oldest_rank;
    logic [PAGE_BITS-1:0] w_page;
    t_cell_ctrl           w_ctrl;

    logic                 w_empty_chain [MAX_FRAMES+1];
    logic                 w_hit_chain   [MAX_FRAMES+1];
    logic [SLOT_W-1:0]    w_slot_chain  [MAX_FRAMES+1];
    logic [PAGE_BITS-1:0] w_ev_chain    [MAX_FRAMES+1];
    logic [SLOT_W-1:0]    w_rank_chain  [MAX_FRAMES+1];

    logic [FAULT_W-1:0]   r_fault;
    logic [FAULT_W-1:0]   w_fault_next;

    logic                   r_out_valid;
    logic                   r_hit;
    logic [SLOT_PORT_W-1:0] r_slot;
    logic                   r_ev_valid;
    logic [PAGE_PORT_W-1:0] r_ev_page;
    logic [FAULT_W-1:0]     r_fault_total;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid;
    assign o_in_ready  = (!r_out_valid || i_out_ready) && !i_cfg_valid;
    assign w_in_fire   = i_in_valid && o_in_ready;

    // frame count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
        end else if (w_cfg_fire) begin
            r_frame_count <= i_frame_count;
        end
    end

    // number of active frames and the rank of the oldest one when all are full
    assign w_fc_ext = CNT_W'(r_frame_count);
    always_comb begin
        if (w_fc_ext == '0) begin
            w_active = CNT_W'(1);
        end else if (w_fc_ext > CNT_W'(MAX_FRAMES)) begin
            w_active = CNT_W'(MAX_FRAMES);
        end else begin
            w_active = w_fc_ext;
        end
    end
    assign w_oldest_rank = SLOT_W'(w_active - CNT_W'(1));

    assign w_page = PAGE_BITS'(i_page_number);

    // chain heads
    assign w_empty_chain[0] = 1'b0;
    assign w_hit_chain[0]   = 1'b0;
    assign w_slot_chain[0]  = '0;
    assign w_ev_chain[0]    = '0;
    assign w_rank_chain[0]  = '0;

    // broadcast control
    assign w_ctrl.step  = w_in_fire;
    assign w_ctrl.clear = w_cfg_fire || (w_in_fire && i_last_reference);
    assign w_ctrl.miss  = !w_hit_chain[MAX_FRAMES];
    assign w_ctrl.full  = !w_empty_chain[MAX_FRAMES];

    // row of frame cells
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        lrupr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .SLOT_W    (SLOT_W),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_active      (CNT_W'(g) < w_active),
            .i_page        (w_page),
            .i_hit_rank    (w_rank_chain[MAX_FRAMES]),
            .i_oldest_rank (w_oldest_rank),
            .i_empty_seen  (w_empty_chain[g]),
            .o_empty_seen  (w_empty_chain[g+1]),
            .i_hit_any     (w_hit_chain[g]),
            .o_hit_any     (w_hit_chain[g+1]),
            .i_slot        (w_slot_chain[g]),
            .o_slot        (w_slot_chain[g+1]),
            .i_ev_page     (w_ev_chain[g]),
            .o_ev_page     (w_ev_chain[g+1]),
            .i_rank_chain  (w_rank_chain[g]),
            .o_rank_chain  (w_rank_chain[g+1])
        );
    end

    // saturating fault count
    assign w_fault_next = (w_ctrl.miss && (r_fault != FAULT_MAX)) ? r_fault + 1'b1 : r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
        end else if (w_ctrl.clear) begin
            r_fault <= '0;
        end else if (w_in_fire) begin
            r_fault <= w_fault_next;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_hit         <= !w_ctrl.miss;
            r_slot        <= SLOT_PORT_W'(w_slot_chain[MAX_FRAMES]);
            r_ev_valid    <= w_ctrl.miss && w_ctrl.full;
            r_ev_page     <= PAGE_PORT_W'(w_ev_chain[MAX_FRAMES]);
            r_fault_total <= w_fault_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_frame_slot    = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_fault_total;

    // an eviction is always a fault with a nonzero count
    a_evict_is_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev_valid) |-> (!r_hit && (r_fault_total != '0)))
        else $error("eviction reported on a hit or with zero fault total");

    // no eviction means the evicted page reads zero
    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ev_valid) |-> (r_ev_page == '0))
        else $error("evicted page nonzero without eviction");

    // a last reference leaves the fault count cleared
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_last_reference) |=> (r_fault == '0))
        else $error("fault count not cleared after last reference");

    // a miss that is not last leaves a nonzero fault count
    a_miss_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_ctrl.miss && !i_last_reference) |=> (r_fault != '0))
        else $error("fault count zero after a miss");

endmodule

// ----- src/lrupr_cell.sv -----
// one page frame: resident page, valid mark and recency rank, chained to its neighbors
module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS = DEF_PAGE_BITS,
    parameter int SLOT_W    = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctrl           i_ctrl,
    input  logic                 i_active,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [SLOT_W-1:0]    i_hit_rank,
    input  logic [SLOT_W-1:0]    i_oldest_rank,
    input  logic                 i_empty_seen,
    output logic                 o_empty_seen,
    input  logic                 i_hit_any,
    output logic                 o_hit_any,
    input  logic [SLOT_W-1:0]    i_slot,
    output logic [SLOT_W-1:0]    o_slot,
    input  logic [PAGE_BITS-1:0] i_ev_page,
    output logic [PAGE_BITS-1:0] o_ev_page,
    input  logic [SLOT_W-1:0]    i_rank_chain,
    output logic [SLOT_W-1:0]    o_rank_chain
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_IDX);

    logic                 r_valid;
    logic [SLOT_W-1:0]    r_rank;
    logic [PAGE_BITS-1:0] r_page;
    logic                 n_valid;
    logic [SLOT_W-1:0]    n_rank;

    logic w_hit;
    logic w_empty;
    logic w_take_empty;
    logic w_victim;
    logic w_place;

    // lookup and placement decisions of this frame
    assign w_hit        = i_active && r_valid && (r_page == i_page);
    assign w_empty      = i_active && !r_valid;
    assign w_take_empty = i_ctrl.miss && w_empty && !i_empty_seen;
    assign w_victim     = i_ctrl.miss && i_ctrl.full && i_active && r_valid &&
                          (r_rank == i_oldest_rank);
    assign w_place      = w_take_empty || w_victim;

    // ripple toward the next cell
    assign o_empty_seen = i_empty_seen || w_empty;
    assign o_hit_any    = i_hit_any || w_hit;
    assign o_slot       = i_slot | ((w_hit || w_place) ? MY_SLOT : '0);
    assign o_ev_page    = i_ev_page | (w_victim ? r_page : '0);
    assign o_rank_chain = i_rank_chain | (w_hit ? r_rank : '0);

    // next valid mark and rank
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
            n_rank  = '0;
        end else if (i_ctrl.step) begin
            if (w_place) begin
                n_valid = 1'b1;
                n_rank  = '0;
            end else if (w_hit) begin
                n_rank = '0;
            end else if (i_active && r_valid && (i_ctrl.miss || (r_rank < i_hit_rank))) begin
                n_rank = r_rank + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    // resident page, written on placement
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step && w_place) begin
            r_page <= i_page;
        end
    end

endmodule
